// File: hdl/emc_pkg.sv
// ----------------------------------------------------------------------------
// emc_pkg
// Shared types, register indexes and helpers for the encoder menu cursor.
// ----------------------------------------------------------------------------
package emc_pkg;

  localparam int unsigned PosW      = 32;
  localparam int unsigned DeltaW    = 33;
  localparam int unsigned SumW      = 34;
  localparam int unsigned CountW    = 16;
  localparam int unsigned RowW      = 8;
  localparam int unsigned SelW      = 11;
  localparam int unsigned DivW      = 5;
  localparam int unsigned DivSteps  = 4;
  localparam int unsigned DivCycles = PosW / DivSteps;
  localparam int unsigned DivCntW   = $clog2(DivCycles);
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;

  localparam logic [CfgIdxW-1:0] RegMenuRows      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVisibleLines  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegClickShift    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegEncoderDiv    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegControlMode   = 3'd4;

  typedef enum logic [1:0] {
    KIND_ENCODER = 2'd0,
    KIND_UP      = 2'd1,
    KIND_DOWN    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_LOAD,
    ST_DIVIDE,
    ST_SIGN,
    ST_DIFF,
    ST_APPLY,
    ST_SCROLL,
    ST_DONE
  } state_e;

  // 4 = 1 mod 3, so the sum of base-4 digits keeps the residue
  function automatic logic div_by_3(input logic [SelW-1:0] v);
    logic [11:0] w;
    logic [4:0]  s1;
    logic [2:0]  s2;
    logic [2:0]  s3;
    w  = {1'b0, v};
    s1 = 5'(w[1:0]) + 5'(w[3:2]) + 5'(w[5:4]) + 5'(w[7:6])
       + 5'(w[9:8]) + 5'(w[11:10]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

endpackage

// File: hdl/encoder_menu_cursor_unit.sv
// ----------------------------------------------------------------------------
// encoder_menu_cursor_unit
// Menu cursor and scrolling window driven by encoder readings and buttons.
// ----------------------------------------------------------------------------
// One word in, one word out. An encoder reading passes through accumulate,
// magnitude, a shared restoring divider retiring four quotient bits per
// cycle, sign, click difference, clamp and scroll. Up and down words go
// straight to clamp and scroll; restart words go straight to the result.
// The input is taken only while the sequencer is idle; a finished result
// waits in its own output register, so the next word may be accepted before
// the previous result has been taken.
module encoder_menu_cursor_unit
  import emc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 kind_i,
  input  logic signed [7:0]          encoder_change_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [CountW-1:0]   selected_count_o,
  output logic [RowW-1:0]            cursor_line_o,
  output logic [RowW-1:0]            window_start_o,
  output logic signed [CountW-1:0]   adjust_count_o,
  output logic                       moved_o,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i
);

  state_e state_q, state_d;

  logic [7:0]          menu_rows_q;
  logic [4:0]          visible_lines_q;
  logic [1:0]          click_shift_q;
  logic [DivW-1:0]     encoder_div_q;
  logic                control_mode_q;

  kind_e               kind_q;
  logic signed [7:0]   change_q;
  logic [PosW-1:0]     pos_q;
  logic [PosW-1:0]     last_q;
  logic                neg_q;
  logic [PosW-1:0]     quo_q, quo_d;
  logic [DivW-1:0]     rem_q, rem_d;
  logic [DivCntW-1:0]  cnt_q;
  logic signed [DeltaW-1:0] delta_q;
  logic [CountW-1:0]   sel_q;
  logic [RowW-1:0]     row_q;
  logic [RowW-1:0]     first_q;
  logic signed [CountW-1:0] adj_q;
  logic                moved_q;

  logic                out_valid_q;
  logic [CountW-1:0]   out_sel_q;
  logic [RowW-1:0]     out_row_q;
  logic [RowW-1:0]     out_first_q;
  logic [CountW-1:0]   out_adj_q;
  logic                out_moved_q;

  logic                in_fire;
  logic                out_load;
  logic                out_free;

  logic [DivW-1:0]     div_eff;
  logic [7:0]          rows_eff;
  logic [4:0]          lines_eff;
  logic [DeltaW-1:0]   step;
  logic signed [DeltaW-1:0] btn_delta;
  logic [PosW-1:0]     pos_sum;
  logic signed [SumW-1:0] msl;
  logic signed [SumW-1:0] top;
  logic [SelW-1:0]     clamp;
  logic                row_hit;
  logic [RowW-1:0]     row_new;
  logic signed [SumW-1:0] adj_sum;
  logic signed [CountW-1:0] adj_sat;
  logic signed [8:0]   sl;
  logic [RowW-1:0]     first_new;
  logic [DivW:0]       rem6;
  logic [DivW-1:0]     rem_t;
  logic [PosW-1:0]     quo_t;

  assign div_eff   = (encoder_div_q == '0) ? DivW'(1) : encoder_div_q;
  assign rows_eff  = (menu_rows_q == '0) ? 8'd1 : menu_rows_q;
  assign lines_eff = (visible_lines_q == '0) ? 5'd1 : visible_lines_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // ---- sequencer -----------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (kind_e'(kind_i))
            KIND_ENCODER: state_d = ST_ACCUM;
            KIND_UP,
            KIND_DOWN:    state_d = ST_APPLY;
            KIND_RESTART: state_d = ST_DONE;
            default:      state_d = ST_DONE;
          endcase
        end
      end
      ST_ACCUM:  state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (cnt_q == DivCntW'(DivCycles - 1)) begin
          state_d = ST_SIGN;
        end
      end
      ST_SIGN:   state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_APPLY;
      ST_APPLY:  state_d = ST_SCROLL;
      ST_SCROLL: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_DONE: out_load   = out_free;
      default: begin
        in_ready_o = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  // ---- shared divider: four restoring steps per cycle ----------------------
  always_comb begin
    rem_t = rem_q;
    quo_t = quo_q;
    rem6  = '0;
    for (int i = 0; i < DivSteps; i++) begin
      rem6  = {rem_t, quo_t[PosW-1]};
      quo_t = {quo_t[PosW-2:0], 1'b0};
      if (rem6 >= {1'b0, div_eff}) begin
        rem6     = rem6 - {1'b0, div_eff};
        quo_t[0] = 1'b1;
      end
      rem_t = rem6[DivW-1:0];
    end
    rem_d = rem_t;
    quo_d = quo_t;
  end

  // ---- move arithmetic -----------------------------------------------------
  always_comb begin
    step      = DeltaW'(click_shift_q) + DeltaW'(1);
    btn_delta = '0;
    if (kind_e'(kind_i) == KIND_UP) begin
      btn_delta = control_mode_q ? DeltaW'(1) : -$signed(step);
    end else begin
      btn_delta = control_mode_q ? -$signed(DeltaW'(1)) : $signed(step);
    end
  end

  assign pos_sum = pos_q + PosW'(change_q);

  always_comb begin
    msl   = $signed(SumW'(sel_q)) + SumW'(delta_q);
    top   = $signed(SumW'({3'b0, rows_eff} << click_shift_q));
    clamp = '0;
    if (msl >= top) begin
      clamp = SelW'({3'b0, rows_eff - 8'd1} << click_shift_q);
    end else if (msl < 0) begin
      clamp = '0;
    end else begin
      clamp = msl[SelW-1:0];
    end
    unique case (click_shift_q)
      2'd0:    row_hit = 1'b1;
      2'd1:    row_hit = (clamp[0] == 1'b0);
      2'd2:    row_hit = div_by_3(clamp);
      2'd3:    row_hit = (clamp[1:0] == 2'b00);
      default: row_hit = 1'b1;
    endcase
    row_new = RowW'(clamp >> click_shift_q);
  end

  always_comb begin
    adj_sum = SumW'(adj_q) + SumW'(delta_q);
    if (adj_sum > SumW'(32767)) begin
      adj_sat = 16'sh7FFF;
    end else if (adj_sum < -SumW'(32768)) begin
      adj_sat = -16'sh8000;
    end else begin
      adj_sat = adj_sum[CountW-1:0];
    end
  end

  always_comb begin
    sl        = $signed({1'b0, row_q}) - $signed({1'b0, first_q});
    first_new = first_q;
    if (rows_eff > {3'b0, lines_eff}) begin
      if (sl >= $signed({4'b0, lines_eff})) begin
        first_new = row_q + 8'd1 - {3'b0, lines_eff};
      end else if (sl < 0) begin
        first_new = row_q;
      end
    end else begin
      first_new = '0;
    end
  end

  // ---- registers -----------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      menu_rows_q     <= 8'd1;
      visible_lines_q <= 5'd4;
      click_shift_q   <= 2'd0;
      encoder_div_q   <= DivW'(4);
      control_mode_q  <= 1'b0;
      pos_q           <= '0;
      last_q          <= '0;
      sel_q           <= '0;
      row_q           <= '0;
      first_q         <= '0;
      adj_q           <= '0;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegMenuRows:     menu_rows_q     <= cfg_data_i;
          RegVisibleLines: visible_lines_q <= cfg_data_i[4:0];
          RegClickShift:   click_shift_q   <= cfg_data_i[1:0];
          RegEncoderDiv:   encoder_div_q   <= cfg_data_i[DivW-1:0];
          RegControlMode:  control_mode_q  <= cfg_data_i[0];
          default:         ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (kind_e'(kind_i) == KIND_RESTART)) begin
            if (control_mode_q) begin
              adj_q <= '0;
            end else begin
              sel_q   <= '0;
              row_q   <= '0;
              first_q <= '0;
            end
          end
        end
        ST_ACCUM:  pos_q <= pos_sum;
        ST_LOAD:   cnt_q <= '0;
        ST_DIVIDE: cnt_q <= cnt_q + DivCntW'(1);
        ST_DIFF:   last_q <= quo_q;
        ST_APPLY: begin
          if (delta_q != '0) begin
            if (control_mode_q) begin
              adj_q <= adj_sat;
            end else begin
              sel_q <= CountW'(clamp);
              if (row_hit) begin
                row_q <= row_new;
              end
            end
          end
        end
        ST_SCROLL: begin
          if (moved_q && !control_mode_q) begin
            first_q <= first_new;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_q   <= kind_e'(kind_i);
          change_q <= encoder_change_i;
          delta_q  <= btn_delta;
          moved_q  <= 1'b0;
        end
      end
      ST_LOAD: begin
        neg_q <= pos_q[PosW-1];
        quo_q <= pos_q[PosW-1] ? (PosW'(0) - pos_q) : pos_q;
        rem_q <= '0;
      end
      ST_DIVIDE: begin
        quo_q <= quo_d;
        rem_q <= rem_d;
      end
      ST_SIGN: begin
        if (neg_q) begin
          quo_q <= PosW'(0) - quo_q;
        end
      end
      ST_DIFF: begin
        delta_q <= $signed({quo_q[PosW-1], quo_q}) - $signed({last_q[PosW-1], last_q});
      end
      ST_APPLY: moved_q <= (delta_q != '0) && (kind_q != KIND_RESTART);
      default: ;
    endcase
    if (out_load) begin
      out_sel_q   <= sel_q;
      out_row_q   <= row_q;
      out_first_q <= first_q;
      out_adj_q   <= adj_q;
      out_moved_q <= moved_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign selected_count_o = $signed(out_sel_q);
  assign cursor_line_o    = out_row_q;
  assign window_start_o   = out_first_q;
  assign adjust_count_o   = $signed(out_adj_q);
  assign moved_o          = out_moved_q;

endmodule
